// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

    // Default limit on the whole frame size, header and checksum included
    localparam int DEFAULT_MAX_FRAME_BYTES = 1024;

    // Header, user id, type, two length bytes, two sequence bytes, checksum
    localparam int FRAME_OVERHEAD = 8;

    // Total length holds a 16-bit payload count plus the overhead
    localparam int TOT_W = 17;

    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int PLEN_W   = 10;
    localparam int CFG_IDX_W = 3;

    // Byte positions of the frame header
    localparam int POS_HEADER  = 0;
    localparam int POS_USER_ID = 1;
    localparam int POS_TYPE    = 2;
    localparam int POS_LEN_LO  = 3;
    localparam int POS_LEN_HI  = 4;
    localparam int POS_SEQ_LO  = 5;
    localparam int POS_SEQ_HI  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_BYTE  = 3'd0,
        REG_USER_ID      = 3'd1,
        REG_SHAKE_TYPE   = 3'd2,
        REG_CONFIRM_TYPE = 3'd3,
        REG_MESSAGE_TYPE = 3'd4,
        REG_CONTROL_TYPE = 3'd5,
        REG_KEEPALIVE    = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        STAT_NONE       = 3'd0,
        STAT_SHAKE_OK   = 3'd1,
        STAT_MESSAGE_OK = 3'd2,
        STAT_OTHER_OK   = 3'd3,
        STAT_CSUM_ERR   = 3'd4,
        STAT_TOO_LONG   = 3'd5
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] expected_user_id;
        logic [BYTE_W-1:0] shake_type_code;
        logic [BYTE_W-1:0] confirm_type_code;
        logic [BYTE_W-1:0] message_type_code;
        logic [BYTE_W-1:0] control_type_code;
        logic              keepalive_enable;
    } cfg_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        status_t           frame_status;
        logic [BYTE_W-1:0] end_type;
        logic [SEQ_W-1:0]  frame_sequence;
        logic [PLEN_W-1:0] payload_length;
        logic              link_ready;
        logic              send_confirm;
    } result_t;

endpackage

// ===== rtl/sfd_cfg_regs.sv =====
`timescale 1ns / 1ps

module sfd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
    output sfd_pkg::cfg_t                 cfg
);
    import sfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes leave everything unchanged
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_BYTE:  cfg_next.header_byte       = cfg_wdata;
                REG_USER_ID:      cfg_next.expected_user_id  = cfg_wdata;
                REG_SHAKE_TYPE:   cfg_next.shake_type_code   = cfg_wdata;
                REG_CONFIRM_TYPE: cfg_next.confirm_type_code = cfg_wdata;
                REG_MESSAGE_TYPE: cfg_next.message_type_code = cfg_wdata;
                REG_CONTROL_TYPE: cfg_next.control_type_code = cfg_wdata;
                REG_KEEPALIVE:    cfg_next.keepalive_enable  = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte       <= 8'hA5;
            cfg_reg.expected_user_id  <= 8'h01;
            cfg_reg.shake_type_code   <= 8'h01;
            cfg_reg.confirm_type_code <= 8'hFF;
            cfg_reg.message_type_code <= 8'h04;
            cfg_reg.control_type_code <= 8'h05;
            cfg_reg.keepalive_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/sfd_parser.sv =====
`timescale 1ns / 1ps

module sfd_parser #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    input  sfd_pkg::cfg_t              cfg,
    output sfd_pkg::result_t           res
);
    import sfd_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              ready_reg, ready_next;

    logic [TOT_W-1:0]  pos_inc;
    logic [BYTE_W-1:0] sum_add;
    logic [TOT_W-1:0]  plen_full;
    logic              is_shake;
    logic              is_confirm;

    assign pos_inc   = TOT_W'(pos_reg) + TOT_W'(1);
    assign sum_add   = sum_reg + rx_byte;
    assign plen_full = total_reg - TOT_W'(FRAME_OVERHEAD);
    assign is_shake   = (type_reg == cfg.shake_type_code);
    assign is_confirm = (type_reg == cfg.confirm_type_code);

    // Next state and result for the byte on the input
    always_comb
    begin
        pos_next    = pos_reg;
        total_next  = total_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        seq_next    = seq_reg;
        ready_next  = ready_reg;

        res = '0;
        res.frame_status = STAT_NONE;

        case (pos_reg)
            POS_W'(POS_HEADER):
            begin
                if (rx_byte == cfg.header_byte)
                begin
                    sum_next = rx_byte;
                    pos_next = POS_W'(POS_USER_ID);
                end
            end
            POS_W'(POS_USER_ID):
            begin
                // Wrong user id drops the frame and resumes the hunt
                if (rx_byte == cfg.expected_user_id)
                begin
                    sum_next = sum_add;
                    pos_next = POS_W'(POS_TYPE);
                end
                else
                begin
                    pos_next   = '0;
                    total_next = '0;
                    sum_next   = '0;
                end
            end
            POS_W'(POS_TYPE):
            begin
                type_next = rx_byte;
                sum_next  = sum_add;
                pos_next  = POS_W'(POS_LEN_LO);
            end
            POS_W'(POS_LEN_LO):
            begin
                len_lo_next = rx_byte;
                sum_next    = sum_add;
                pos_next    = POS_W'(POS_LEN_HI);
            end
            POS_W'(POS_LEN_HI):
            begin
                total_next = TOT_W'({rx_byte, len_lo_reg}) + TOT_W'(FRAME_OVERHEAD);
                sum_next   = sum_add;
                pos_next   = POS_W'(POS_SEQ_LO);
            end
            POS_W'(POS_SEQ_LO):
            begin
                seq_next = {8'h00, rx_byte};
                sum_next = sum_add;
                pos_next = POS_W'(POS_SEQ_HI);
            end
            POS_W'(POS_SEQ_HI):
            begin
                seq_next = {rx_byte, seq_reg[BYTE_W-1:0]};
                sum_next = sum_add;
                pos_next = POS_W'(POS_SEQ_HI + 1);
                // Reject an oversized frame right after its header
                if (total_reg > TOT_W'(MAX_FRAME_BYTES))
                begin
                    res.frame_end    = 1'b1;
                    res.frame_status = STAT_TOO_LONG;
                end
            end
            default:
            begin
                // Payload bytes, then the checksum byte
                if (pos_inc < total_reg)
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_byte;
                end
                sum_next = sum_add;
                pos_next = pos_inc[POS_W-1:0];
                if (pos_inc >= total_reg)
                begin
                    res.frame_end = 1'b1;
                    if (sum_add != '0)
                    begin
                        res.frame_status = STAT_CSUM_ERR;
                    end
                    else if (is_shake || is_confirm)
                    begin
                        res.frame_status = STAT_SHAKE_OK;
                        ready_next       = 1'b1;
                        res.send_confirm = cfg.keepalive_enable && is_shake;
                    end
                    else if (type_reg == cfg.message_type_code)
                    begin
                        res.frame_status = STAT_MESSAGE_OK;
                        ready_next       = 1'b1;
                    end
                    else
                    begin
                        res.frame_status = STAT_OTHER_OK;
                        if (type_reg == cfg.control_type_code)
                        begin
                            ready_next = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Frame summary fields show only on the closing byte
        if (res.frame_end)
        begin
            res.end_type       = type_next;
            res.frame_sequence = seq_next;
            res.payload_length = plen_full[PLEN_W-1:0];
            pos_next   = '0;
            total_next = '0;
            sum_next   = '0;
        end
        res.link_ready = ready_next;
    end

    // Advance the frame state on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            total_reg  <= '0;
            sum_reg    <= '0;
            type_reg   <= '0;
            len_lo_reg <= '0;
            seq_reg    <= '0;
            ready_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            len_lo_reg <= len_lo_next;
            seq_reg    <= seq_next;
            ready_reg  <= ready_next;
        end
    end

    // A closed or rejected frame always restarts the hunt
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.frame_end |=> pos_reg == '0 && sum_reg == '0)
    else $error("frame end did not restart the hunt");

    // Payload and frame end never share a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res.payload_valid && res.frame_end))
    else $error("payload byte flagged as frame end");

    // Confirm requests come only with a good handshake frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res.send_confirm |-> res.frame_end && res.frame_status == STAT_SHAKE_OK)
    else $error("confirm request without good handshake");

    // Link ready is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> ready_reg)
    else $error("link ready flag dropped");

endmodule

// ===== rtl/sfd_out_stage.sv =====
`timescale 1ns / 1ps

module sfd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfd_pkg::result_t in_res,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t out_res
);
    import sfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Take a new result whenever the held one leaves or the slot is empty
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/serial_frame_deframer_checksum.sv =====
`timescale 1ns / 1ps
// A result appears on m_tvalid in the cycle after its byte transfers on the slave side.
// Throughput: one byte per cycle unless m_tready stalls the output; state updates per byte.
// A new byte transfers in the cycle the held result leaves; a stalled result holds s_tready low.
// Reset (rst_n low, asynchronous) clears frame state, link ready and the output valid,
// and loads the configuration registers with their default values.

module serial_frame_deframer_checksum #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
    // Received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                                     // [18:11] end_type,
                                                     // [34:19] frame_sequence,
                                                     // [44:35] payload_length,
                                                     // [45] link_ready, [46] send_confirm,
                                                     // [47] zero
    output logic                          m_tlast,   // frame_end
    output logic                          m_tuser    // payload_valid
);
    import sfd_pkg::*;

    cfg_t    cfg;
    result_t parse_res;
    result_t out_res;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    sfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .res     (parse_res)
    );

    sfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the master side
    assign m_tdata = {1'b0,
                      out_res.send_confirm,
                      out_res.link_ready,
                      out_res.payload_length,
                      out_res.frame_sequence,
                      out_res.end_type,
                      3'(out_res.frame_status),
                      out_res.payload_byte};
    assign m_tlast = out_res.frame_end;
    assign m_tuser = out_res.payload_valid;

endmodule
